FILE: rtl/hodp_pkg.sv
// Shared types, phase codes and character helpers for the number parser.
`timescale 1ns / 1ps

package hodp_pkg;

    // Parse phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_NUM   = 3'd2;
    localparam logic [2:0] PH_ZERO  = 3'd3;
    localparam logic [2:0] PH_DEC   = 3'd4;
    localparam logic [2:0] PH_HEX   = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    // Character codes
    localparam logic [15:0] CH_MINUS   = 16'h002D;
    localparam logic [15:0] CH_ZERO    = 16'h0030;
    localparam logic [15:0] CH_X_LOWER = 16'h0078;
    localparam logic [15:0] CH_X_UPPER = 16'h0058;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // One input character with its restart flag
    typedef struct packed {
        logic [15:0] character;
        logic        first_char;
    } hodp_item_t;

    // One parse result
    typedef struct packed {
        logic        ok;
        logic [63:0] value;
        logic [15:0] consumed;
    } hodp_result_t;

    function automatic logic is_dec(input logic [15:0] c);
        is_dec = (c inside {[16'h0030:16'h0039]});
    endfunction

    function automatic logic is_hex(input logic [15:0] c);
        is_hex = (c inside {[16'h0030:16'h0039], [16'h0061:16'h0066],
                            [16'h0041:16'h0046]});
    endfunction

    // Value of a hex digit; decimal digits map the same way
    function automatic logic [3:0] hex_val(input logic [15:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[16'h0030:16'h0039]})
        begin
            v = c[3:0];
        end
        else if (c inside {[16'h0061:16'h0066], [16'h0041:16'h0046]})
        begin
            // 'a'..'f' and 'A'..'F' both have low bits 1..6
            v = c[3:0] + 4'd9;
        end
        hex_val = v;
    endfunction

endpackage

FILE: rtl/hodp_in_stage.sv
// Input register stage: holds one character transfer until the parser takes it.
`timescale 1ns / 1ps

module hodp_in_stage
    import hodp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [15:0] character,
    input  logic       first_char,
    input  logic       take,
    output logic       item_valid,
    output hodp_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    hodp_item_t item_reg;
    logic       accept;

    // Stall only while the held character cannot move on
    assign in_stall = valid_reg && !take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.character  <= character;
            item_reg.first_char <= first_char;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/hodp_parser.sv
// Parse state registers and the combinational per-character update.
`timescale 1ns / 1ps

module hodp_parser
    import hodp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  hodp_item_t   item,
    output logic         emit,
    output hodp_result_t result
);

    logic [2:0]  phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        seen_reg, seen_next;
    logic [15:0] cnt_reg, cnt_next;

    // State as seen after an optional restart
    logic [2:0]  phase_eff;
    logic [63:0] acc_eff;
    logic        neg_eff;
    logic        seen_eff;
    logic [15:0] cnt_eff;
    logic [15:0] cnt_inc;

    logic [15:0] c;
    logic        c_dec;
    logic        c_hex;
    logic [63:0] digit;
    logic [63:0] acc_x10;
    logic [63:0] acc_x16;
    logic        finish;

    assign c       = item.character;
    assign c_dec   = is_dec(c);
    assign c_hex   = is_hex(c);
    assign digit   = {60'd0, hex_val(c)};
    assign acc_x10 = {acc_eff[60:0], 3'b000} + {acc_eff[62:0], 1'b0};
    assign acc_x16 = {acc_eff[59:0], 4'b0000};

    always_comb
    begin
        phase_eff = item.first_char ? PH_START : phase_reg;
        acc_eff   = item.first_char ? 64'd0 : acc_reg;
        neg_eff   = item.first_char ? 1'b0 : neg_reg;
        seen_eff  = item.first_char ? 1'b0 : seen_reg;
        cnt_eff   = item.first_char ? 16'd0 : cnt_reg;
    end

    // Saturating character count
    assign cnt_inc = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + 16'd1;

    // Per-character grammar step
    always_comb
    begin
        phase_next = phase_eff;
        acc_next   = acc_eff;
        neg_next   = neg_eff;
        seen_next  = seen_eff;
        cnt_next   = cnt_eff;
        finish     = 1'b0;
        case (phase_eff)
            PH_START, PH_NUM:
            begin
                if (phase_eff == PH_START && c == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    cnt_next   = cnt_inc;
                    phase_next = PH_NUM;
                end
                else if (c == CH_ZERO)
                begin
                    seen_next  = 1'b1;
                    cnt_next   = cnt_inc;
                    phase_next = PH_ZERO;
                end
                else if (c_dec)
                begin
                    acc_next   = digit;
                    seen_next  = 1'b1;
                    cnt_next   = cnt_inc;
                    phase_next = PH_DEC;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_ZERO, PH_DEC:
            begin
                if (phase_eff == PH_ZERO && (c == CH_X_LOWER || c == CH_X_UPPER))
                begin
                    // leading zero becomes the hex prefix
                    seen_next  = 1'b0;
                    cnt_next   = cnt_inc;
                    phase_next = PH_HEX;
                end
                else if (c_dec)
                begin
                    acc_next   = acc_x10 + digit;
                    cnt_next   = cnt_inc;
                    phase_next = PH_DEC;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (c_hex)
                begin
                    acc_next  = acc_x16 + digit;
                    seen_next = 1'b1;
                    cnt_next  = cnt_inc;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                // idle before any string, or done: ignore the character
            end
        endcase
        if (finish)
        begin
            phase_next = PH_DONE;
        end
    end

    // Result formed from the state at the terminating character
    always_comb
    begin
        result.ok       = seen_eff;
        result.value    = 64'd0;
        result.consumed = 16'd0;
        if (seen_eff)
        begin
            result.value    = neg_eff ? (64'd0 - acc_eff) : acc_eff;
            result.consumed = cnt_eff;
        end
    end

    assign emit = step && finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= 64'd0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            cnt_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> phase_reg == PH_DONE)
        else $error("parser not done after emitting a result");

    a_idle_until_first: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE && !(step && item.first_char) |=> phase_reg == PH_IDLE)
        else $error("parser left idle without a first character");

    a_ok_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        emit && result.ok |-> result.consumed != 16'd0)
        else $error("successful result with zero consumed count");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !result.ok |-> result.value == 64'd0 && result.consumed == 16'd0)
        else $error("failed result with nonzero fields");
`endif

endmodule

FILE: rtl/hex_or_decimal_number_parser_core.sv
// Top level: input stage, parser and result register of the number parser.
// Path: the terminating character is parsed from the input register straight into
//   the result register, which then presents the result on the outputs.
// Throughput: one character per cycle unless out_stall holds a pending result.
// Reset (rst_n, async, active low) clears valids and puts the parser in idle,
//   where characters are ignored until one arrives with first_char set.
`timescale 1ns / 1ps

module hex_or_decimal_number_parser_core
    import hodp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] character,
    input  logic        first_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [63:0] value,
    output logic [15:0] consumed
);

    logic         item_valid;
    hodp_item_t   item;
    logic         out_free;
    logic         step;
    logic         emit;
    hodp_result_t result;

    logic         out_valid_reg, out_valid_next;
    hodp_result_t out_reg;

    // Parser advances when the result slot is free or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = item_valid && out_free;

    hodp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .character  (character),
        .first_char (first_char),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    hodp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .emit   (emit),
        .result (result)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = out_reg.ok;
    assign value     = out_reg.value;
    assign consumed  = out_reg.consumed;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !emit)
        else $error("result overwritten while stalled");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid && out_valid_reg && out_stall)
        else $error("input stalled without a full pipeline");

    a_emit_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted result not presented");
`endif

endmodule
